// File: rtl/cvz_pkg.sv
package cvz_pkg;

    localparam int FIELD_W   = 32;
    localparam int ZOOM_W    = 24;
    localparam int OP_W      = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int WIDE_W    = 64;

    localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sd1 <<< 61;
    localparam logic signed [WIDE_W-1:0] ZOOM_ONE = 64'sd65536;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 3'd0,
        OP_ZOOM = 3'd1,
        OP_PAN  = 3'd2,
        OP_D2P  = 3'd3,
        OP_P2D  = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    // datapath step selector
    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_LOAD,
        SEL_D2P_X,
        SEL_D2P_Y,
        SEL_P2D_X,
        SEL_P2D_Y,
        SEL_ZR_X,
        SEL_ZR_Y,
        SEL_ZN_X,
        SEL_ZN_Y,
        SEL_PAN_X,
        SEL_PAN_Y
    } t_sel;

    typedef struct packed {
        logic capture;
        logic md_start;
        logic post;
        logic out_wr;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fzero;
    } t_stat;

endpackage

// File: rtl/cvz_muldiv.sv
// round(a*b/d), ties away from zero, clamped to +-2^61; d > 0
module cvz_muldiv (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cvz_pkg::WIDE_W-1:0]   i_a,
    input  logic signed [cvz_pkg::WIDE_W-1:0]   i_b,
    input  logic        [cvz_pkg::WIDE_W-1:0]   i_d,
    output logic                                o_done,
    output logic signed [cvz_pkg::WIDE_W-1:0]   o_q
);
    localparam int W  = cvz_pkg::WIDE_W;
    localparam int W2 = 2 * W;
    localparam int LB = 62;   // quotient bits developed by the divider

    typedef enum logic [2:0] {M_IDLE, M_MUL, M_CHK, M_DIV, M_FIN} t_mstate;

    t_mstate          r_state;
    logic             r_neg;
    logic [W2-1:0]    r_acc;
    logic [W2-1:0]    r_mc;
    logic [W-1:0]     r_mp;
    logic [W-1:0]     r_d;
    logic [W-1:0]     r_rem;
    logic [LB-1:0]    r_low;
    logic [W-1:0]     r_quo;
    logic [5:0]       r_cnt;

    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    logic [W2-LB-1:0] hi;
    logic [W:0]       rem2;
    logic             ge;
    logic [W-1:0]     quo_c;

    assign mag_a = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign mag_b = i_b[W-1] ? W'(-i_b) : W'(i_b);
    assign hi    = r_acc[W2-1:LB];
    assign rem2  = {r_rem, r_low[LB-1]};
    assign ge    = rem2 >= {1'b0, r_d};
    assign quo_c = (r_quo > W'(cvz_pkg::WIDE_LIM)) ? W'(cvz_pkg::WIDE_LIM) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_a[W-1] != i_b[W-1];
                        r_acc   <= '0;
                        r_mc    <= {{W{1'b0}}, mag_a};
                        r_mp    <= mag_b;
                        r_d     <= i_d;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    if (r_mp == '0) begin
                        r_acc   <= r_acc + {{(W+1){1'b0}}, r_d[W-1:1]};
                        r_state <= M_CHK;
                    end else begin
                        if (r_mp[0]) r_acc <= r_acc + r_mc;
                        r_mc <= r_mc << 1;
                        r_mp <= r_mp >> 1;
                    end
                end
                M_CHK: begin
                    // quotient of 2^62 or more saturates at once
                    if (hi >= {{(W2-LB-W){1'b0}}, r_d}) begin
                        r_quo   <= W'(cvz_pkg::WIDE_LIM);
                        r_state <= M_FIN;
                    end else begin
                        r_rem   <= hi[W-1:0];
                        r_low   <= r_acc[LB-1:0];
                        r_quo   <= '0;
                        r_cnt   <= 6'(LB - 1);
                        r_state <= M_DIV;
                    end
                end
                M_DIV: begin
                    r_rem <= ge ? W'(rem2 - {1'b0, r_d}) : rem2[W-1:0];
                    r_quo <= {r_quo[W-2:0], ge};
                    r_low <= r_low << 1;
                    if (r_cnt == '0) r_state <= M_FIN;
                    else r_cnt <= r_cnt - 6'd1;
                end
                M_FIN: begin
                    o_q     <= r_neg ? -$signed(quo_c) : $signed(quo_c);
                    o_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/cvz_ctrl.sv
module cvz_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  logic           i_md_done,
    input  cvz_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output cvz_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {C_IDLE, C_DISP, C_LOADP, C_START, C_WAIT, C_FIN} t_cstate;

    t_cstate       r_state;
    cvz_pkg::t_sel r_sel;
    logic          r_ovalid;
    logic          out_free;
    cvz_pkg::t_sel first_sel;
    cvz_pkg::t_sel next_sel;

    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        unique case (i_stat.op)
            cvz_pkg::OP_LOAD: first_sel = cvz_pkg::SEL_LOAD;
            cvz_pkg::OP_ZOOM: first_sel = i_stat.fzero ? cvz_pkg::SEL_NONE
                                                       : cvz_pkg::SEL_P2D_X;
            cvz_pkg::OP_PAN:  first_sel = cvz_pkg::SEL_PAN_X;
            cvz_pkg::OP_D2P:  first_sel = cvz_pkg::SEL_D2P_X;
            cvz_pkg::OP_P2D:  first_sel = cvz_pkg::SEL_P2D_X;
            default:          first_sel = cvz_pkg::SEL_NONE;
        endcase
    end

    always_comb begin
        unique case (r_sel)
            cvz_pkg::SEL_P2D_X: next_sel = cvz_pkg::SEL_P2D_Y;
            cvz_pkg::SEL_P2D_Y: next_sel = (i_stat.op == cvz_pkg::OP_ZOOM)
                                           ? cvz_pkg::SEL_ZR_X : cvz_pkg::SEL_NONE;
            cvz_pkg::SEL_ZR_X:  next_sel = cvz_pkg::SEL_ZR_Y;
            cvz_pkg::SEL_ZR_Y:  next_sel = cvz_pkg::SEL_ZN_X;
            cvz_pkg::SEL_ZN_X:  next_sel = cvz_pkg::SEL_ZN_Y;
            cvz_pkg::SEL_D2P_X: next_sel = cvz_pkg::SEL_D2P_Y;
            cvz_pkg::SEL_PAN_X: next_sel = cvz_pkg::SEL_PAN_Y;
            default:            next_sel = cvz_pkg::SEL_NONE;
        endcase
    end

    assign o_in_stall      = r_state != C_IDLE;
    assign o_out_valid     = r_ovalid;
    assign o_cmd.capture   = (r_state == C_IDLE) && i_in_valid;
    assign o_cmd.md_start  = r_state == C_START;
    assign o_cmd.post      = (r_state == C_LOADP) || ((r_state == C_WAIT) && i_md_done);
    assign o_cmd.out_wr    = (r_state == C_FIN) && out_free;
    assign o_cmd.sel       = r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_sel    <= cvz_pkg::SEL_NONE;
            r_ovalid <= 1'b0;
        end else begin
            // new result replaces the one taken this cycle
            if ((r_state == C_FIN) && out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                C_IDLE:  if (i_in_valid) r_state <= C_DISP;
                C_DISP: begin
                    r_sel <= first_sel;
                    if (first_sel == cvz_pkg::SEL_NONE) r_state <= C_FIN;
                    else if (first_sel == cvz_pkg::SEL_LOAD) r_state <= C_LOADP;
                    else r_state <= C_START;
                end
                C_LOADP: r_state <= C_FIN;
                C_START: r_state <= C_WAIT;
                C_WAIT: begin
                    if (i_md_done) begin
                        r_sel <= next_sel;
                        r_state <= (next_sel == cvz_pkg::SEL_NONE) ? C_FIN : C_START;
                    end
                end
                C_FIN: begin
                    if (out_free) r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/cvz_datapath.sv
module cvz_datapath #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cvz_pkg::t_cmd                        i_cmd,
    output cvz_pkg::t_stat                       o_stat,
    input  logic                                 i_cfg_we,
    input  logic [cvz_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [cvz_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [cvz_pkg::OP_W-1:0]             i_op,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_x_low,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_x_high,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_y_low,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_y_high,
    input  logic [cvz_pkg::ZOOM_W-1:0]           i_zoom_factor,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_point_x,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_point_y,
    output logic signed [cvz_pkg::WIDE_W-1:0]    o_md_a,
    output logic signed [cvz_pkg::WIDE_W-1:0]    o_md_b,
    output logic        [cvz_pkg::WIDE_W-1:0]    o_md_d,
    input  logic signed [cvz_pkg::WIDE_W-1:0]    i_md_q,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_mapped_x,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_mapped_y,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_x_min,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_x_max,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_y_min,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_y_max,
    output logic                                 o_rejected
);
    localparam int CW = COORD_WIDTH;
    localparam int W  = cvz_pkg::WIDE_W;
    localparam int FW = cvz_pkg::FIELD_W;
    localparam logic signed [W-1:0]  CMAX   = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [W-1:0]  CMIN   = -CMAX - 64'sd1;
    localparam logic signed [CW-1:0] CMAX_C = CMAX[CW-1:0];
    localparam logic signed [W-1:0]  ONE_Q  = 64'sd1 <<< FRAC_BITS;

    function automatic logic signed [CW-1:0] sat(input logic signed [W-1:0] v);
        if (v > CMAX) return CMAX[CW-1:0];
        if (v < CMIN) return CMIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic logic signed [W-1:0] wx(input logic signed [CW-1:0] v);
        return {{(W-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] fx(input logic signed [FW-1:0] v);
        return {{(W-FW){v[FW-1]}}, v};
    endfunction

    function automatic logic signed [FW-1:0] ox(input logic signed [CW-1:0] v);
        logic signed [W-1:0] e;
        e = wx(v);
        return e[FW-1:0];
    endfunction

    // keep max strictly above min
    function automatic logic [2*CW-1:0] norm(input logic signed [CW-1:0] mn,
                                             input logic signed [CW-1:0] mx);
        if (mx <= mn) begin
            if (mn >= CMAX_C) return {CMAX_C - CW'(1), CMAX_C};
            return {mn, mn + CW'(1)};
        end
        return {mn, mx};
    endfunction

    logic [cvz_pkg::CFG_W-1:0]   r_left, r_bottom, r_width, r_height;
    logic signed [CW-1:0]        r_wxn, r_wxx, r_wyn, r_wyx;
    logic signed [CW-1:0]        r_px, r_py, r_mx, r_my;
    logic signed [CW-1:0]        r_xl, r_xh, r_yl, r_yh;
    logic [cvz_pkg::ZOOM_W-1:0]  r_f;
    logic [cvz_pkg::OP_W-1:0]    r_op;
    logic signed [W-1:0]         r_t0, r_t1;

    logic signed [W-1:0] ql, qb, qw, qh, sxw, syw, pxe, pye, q;
    logic [cvz_pkg::CFG_W-1:0] wq, hq;
    logic signed [CW-1:0] nmin, nmax, lxh, lyh;
    logic signed [CW-1:0] a_min, a_max, b_min, b_max;
    logic [2*CW-1:0] nrm_a, nrm_b;

    assign wq  = (r_width  == '0) ? cvz_pkg::CFG_W'(1) : r_width;
    assign hq  = (r_height == '0) ? cvz_pkg::CFG_W'(1) : r_height;
    assign ql  = $signed({{(W-cvz_pkg::CFG_W){1'b0}}, r_left}   << FRAC_BITS);
    assign qb  = $signed({{(W-cvz_pkg::CFG_W){1'b0}}, r_bottom} << FRAC_BITS);
    assign qw  = $signed({{(W-cvz_pkg::CFG_W){1'b0}}, wq}       << FRAC_BITS);
    assign qh  = $signed({{(W-cvz_pkg::CFG_W){1'b0}}, hq}       << FRAC_BITS);
    assign sxw = wx(r_wxx) - wx(r_wxn);
    assign syw = wx(r_wyx) - wx(r_wyn);
    assign pxe = wx(r_px);
    assign pye = wx(r_py);
    assign q   = i_md_q;

    assign o_stat.op    = r_op;
    assign o_stat.fzero = r_f == '0;

    // operands of the shared product-quotient unit
    always_comb begin
        unique case (i_cmd.sel)
            cvz_pkg::SEL_D2P_X: begin o_md_a = pxe - wx(r_wxn); o_md_b = qw;  o_md_d = sxw; end
            cvz_pkg::SEL_D2P_Y: begin o_md_a = pye - wx(r_wyn); o_md_b = qh;  o_md_d = syw; end
            cvz_pkg::SEL_P2D_X: begin o_md_a = pxe - ql; o_md_b = sxw; o_md_d = qw; end
            cvz_pkg::SEL_P2D_Y: begin o_md_a = qb - pye; o_md_b = syw; o_md_d = qh; end
            cvz_pkg::SEL_ZR_X: begin
                o_md_a = sxw; o_md_b = cvz_pkg::ZOOM_ONE; o_md_d = W'(r_f);
            end
            cvz_pkg::SEL_ZR_Y: begin
                o_md_a = syw; o_md_b = cvz_pkg::ZOOM_ONE; o_md_d = W'(r_f);
            end
            cvz_pkg::SEL_ZN_X:  begin o_md_a = r_t0; o_md_b = pxe - ql; o_md_d = qw; end
            cvz_pkg::SEL_ZN_Y:  begin o_md_a = r_t1; o_md_b = qb - pye; o_md_d = qh; end
            cvz_pkg::SEL_PAN_X: begin o_md_a = pxe; o_md_b = sxw; o_md_d = qw; end
            cvz_pkg::SEL_PAN_Y: begin o_md_a = pye; o_md_b = syw; o_md_d = qh; end
            default:            begin o_md_a = '0; o_md_b = '0; o_md_d = W'(1); end
        endcase
    end

    // window update candidates
    always_comb begin
        lxh   = (r_xh <= r_xl) ? sat(wx(r_xl) + ONE_Q) : r_xh;
        lyh   = (r_yh <= r_yl) ? sat(wx(r_yl) + ONE_Q) : r_yh;
        nmin  = '0;
        nmax  = '0;
        a_min = r_wxn; a_max = r_wxx;
        b_min = r_wyn; b_max = r_wyx;
        unique case (i_cmd.sel)
            cvz_pkg::SEL_LOAD: begin
                a_min = r_xl; a_max = lxh;
                b_min = r_yl; b_max = lyh;
            end
            cvz_pkg::SEL_ZN_X: begin
                nmin  = sat(wx(r_mx) - q);
                nmax  = sat(wx(nmin) + r_t0);
                a_min = nmin; a_max = nmax;
            end
            cvz_pkg::SEL_ZN_Y: begin
                nmin  = sat(wx(r_my) - q);
                nmax  = sat(wx(nmin) + r_t1);
                b_min = nmin; b_max = nmax;
            end
            cvz_pkg::SEL_PAN_X: begin
                a_min = sat(wx(r_wxn) - q);
                a_max = sat(wx(r_wxx) - q);
            end
            cvz_pkg::SEL_PAN_Y: begin
                b_min = sat(wx(r_wyn) + q);
                b_max = sat(wx(r_wyx) + q);
            end
            default: ;
        endcase
        nrm_a = norm(a_min, a_max);
        nrm_b = norm(b_min, b_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= cvz_pkg::CFG_W'(0);
            r_bottom <= cvz_pkg::CFG_W'(480);
            r_width  <= cvz_pkg::CFG_W'(640);
            r_height <= cvz_pkg::CFG_W'(480);
            r_wxn    <= '0;
            r_wxx    <= sat(ONE_Q);
            r_wyn    <= '0;
            r_wyx    <= sat(ONE_Q);
            r_op     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    cvz_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                    cvz_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                    cvz_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    cvz_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.capture) r_op <= i_op;
            if (i_cmd.post) begin
                unique case (i_cmd.sel)
                    cvz_pkg::SEL_LOAD, cvz_pkg::SEL_ZN_X, cvz_pkg::SEL_PAN_X: begin
                        {r_wxn, r_wxx} <= nrm_a;
                        if (i_cmd.sel == cvz_pkg::SEL_LOAD) {r_wyn, r_wyx} <= nrm_b;
                    end
                    cvz_pkg::SEL_ZN_Y, cvz_pkg::SEL_PAN_Y: {r_wyn, r_wyx} <= nrm_b;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_xl <= sat(fx(i_range_x_low));
            r_xh <= sat(fx(i_range_x_high));
            r_yl <= sat(fx(i_range_y_low));
            r_yh <= sat(fx(i_range_y_high));
            r_f  <= i_zoom_factor;
            r_px <= sat(fx(i_point_x));
            r_py <= sat(fx(i_point_y));
        end
        if (i_cmd.post) begin
            unique case (i_cmd.sel)
                cvz_pkg::SEL_D2P_X: r_mx <= sat(ql + q);
                cvz_pkg::SEL_D2P_Y: r_my <= sat(qb - q);
                cvz_pkg::SEL_P2D_X: r_mx <= sat(wx(r_wxn) + q);
                cvz_pkg::SEL_P2D_Y: r_my <= sat(wx(r_wyn) + q);
                cvz_pkg::SEL_ZR_X:  r_t0 <= (q < 64'sd1) ? 64'sd1 : q;
                cvz_pkg::SEL_ZR_Y:  r_t1 <= (q < 64'sd1) ? 64'sd1 : q;
                default: ;
            endcase
        end
        if (i_cmd.out_wr) begin
            if (r_op == cvz_pkg::OP_D2P || r_op == cvz_pkg::OP_P2D) begin
                o_mapped_x <= ox(r_mx);
                o_mapped_y <= ox(r_my);
            end else begin
                o_mapped_x <= '0;
                o_mapped_y <= '0;
            end
            o_view_x_min <= ox(r_wxn);
            o_view_x_max <= ox(r_wxx);
            o_view_y_min <= ox(r_wyn);
            o_view_y_max <= ox(r_wyx);
            o_rejected   <= (r_op == cvz_pkg::OP_ZOOM) && (r_f == '0);
        end
    end
endmodule

// File: rtl/chart_viewport_zoom_pan_mapper.sv
// Load range, unused op codes and a refused zoom run no product-quotient. Maps
// and pan run two product-quotients, zoom six; each multiplies one shift-add
// bit per cycle over the bit length of its second multiplier operand, then runs
// 62 restoring divide steps (fewer if the quotient saturates).
// One transaction at a time. Reset (synchronous, active low): window 0..1.0 on
// both axes, plot left 0, bottom 480, width 640, height 480, no result pending.
module chart_viewport_zoom_pan_mapper #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [cvz_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [cvz_pkg::CFG_W-1:0]            i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [cvz_pkg::OP_W-1:0]             i_op,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_x_low,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_x_high,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_y_low,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_range_y_high,
    input  logic [cvz_pkg::ZOOM_W-1:0]           i_zoom_factor,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_point_x,
    input  logic signed [cvz_pkg::FIELD_W-1:0]   i_point_y,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_mapped_x,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_mapped_y,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_x_min,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_x_max,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_y_min,
    output logic signed [cvz_pkg::FIELD_W-1:0]   o_view_y_max,
    output logic                                 o_rejected
);
    // controller walks the step list of each op; datapath holds window,
    // plot registers and operand muxing; one shared product-quotient unit
    cvz_pkg::t_cmd  cmd;
    cvz_pkg::t_stat stat;
    logic           md_done;
    logic signed [cvz_pkg::WIDE_W-1:0] md_a, md_b, md_q;
    logic        [cvz_pkg::WIDE_W-1:0] md_d;

    cvz_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_md_done   (md_done),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cvz_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd.md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    cvz_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_range_x_low  (i_range_x_low),
        .i_range_x_high (i_range_x_high),
        .i_range_y_low  (i_range_y_low),
        .i_range_y_high (i_range_y_high),
        .i_zoom_factor  (i_zoom_factor),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_md_a         (md_a),
        .o_md_b         (md_b),
        .o_md_d         (md_d),
        .i_md_q         (md_q),
        .o_mapped_x     (o_mapped_x),
        .o_mapped_y     (o_mapped_y),
        .o_view_x_min   (o_view_x_min),
        .o_view_x_max   (o_view_x_max),
        .o_view_y_min   (o_view_y_min),
        .o_view_y_max   (o_view_y_max),
        .o_rejected     (o_rejected)
    );
endmodule

// File: rtl/cvz_checker.sv
module cvz_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [cvz_pkg::FIELD_W-1:0]  o_mapped_x,
    input logic signed [cvz_pkg::FIELD_W-1:0]  o_mapped_y,
    input logic                                o_rejected
);
    // one transaction in flight: accept closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    a_reject_no_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (o_mapped_x == '0 && o_mapped_y == '0))
        else $error("rejected zoom carries mapped data");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_mapped_x)))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind chart_viewport_zoom_pan_mapper cvz_checker u_cvz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_mapped_x  (o_mapped_x),
    .o_mapped_y  (o_mapped_y),
    .o_rejected  (o_rejected)
);
